// ===== rtl/core/minimum_spanning_tree_boruvka_top_defines.svh =====
// Assertion macros for the Boruvka spanning-tree block.
// Used by minimum_spanning_tree_boruvka_top; no other dependencies.
`ifndef MINIMUM_SPANNING_TREE_BORUVKA_TOP_DEFINES_SVH
`define MINIMUM_SPANNING_TREE_BORUVKA_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define MSTB_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MSTB_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MSTB_ASSERT(label, clk, rst, prop, msg)
`define MSTB_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ===== rtl/core/mstb_pkg.sv =====
// Shared types and constants for the Boruvka spanning-tree block.
// No dependencies.
package mstb_pkg;
  localparam int VBITS = 5;
  localparam int WBITS = 16;
  localparam int MAX_VERTICES = 32;

  typedef struct packed {
    logic [WBITS-1:0] w;
    logic [VBITS-1:0] v;
    logic [VBITS-1:0] u;
  } edge_t;

  typedef struct packed {
    logic             last;
    logic             dropped;
    logic             spanning;
    logic             valid;
    logic [WBITS-1:0] w;
    logic [VBITS-1:0] v;
    logic [VBITS-1:0] u;
  } result_t;
endpackage

// ===== rtl/core/mstb_edge_mem.sv =====
// Edge store: synchronous single-write, single-read RAM with registered read.
// Uses mstb_pkg.
module mstb_edge_mem #(
  parameter int DEPTH = 256,
  parameter int ABITS = 8
) (
  input  logic           clk,
  input  logic           we,
  input  logic [ABITS-1:0] waddr,
  input  mstb_pkg::edge_t wdata,
  input  logic [ABITS-1:0] raddr,
  output mstb_pkg::edge_t rdata
);
  mstb_pkg::edge_t mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/core/minimum_spanning_tree_boruvka_top.sv =====
// Boruvka minimum spanning tree: edge loader, round sequencer, result queue.
// Uses mstb_pkg, mstb_edge_mem and minimum_spanning_tree_boruvka_top_defines.svh.
//
// channel  dir  tdata fields (low bit up)                       tuser/tlast
// s_axis   in   edge_u[4:0] edge_v[9:5] edge_weight[25:10]      tlast=last_edge
// m_axis   out  tree_u tree_v tree_weight edge_valid spanning   tlast=last_result
//               edges_dropped
// cfg      in   vertex_count[5:0]
//
// Edges are written to the edge store as they are accepted. After the last edge,
// each round scans the edge store once through the edge RAM read port, then
// visits one component per cycle, except that a kept edge is reread and checked
// (S_MRD, S_MCHK) and each merge relabels all MAX_VERTICES entries (S_RELAB).
// Each result is read (S_OUTRD, S_OUTW), then held in S_OUT until it is taken.
// Reset is synchronous; input stalls while running.
`include "minimum_spanning_tree_boruvka_top_defines.svh"
module minimum_spanning_tree_boruvka_top #(
  parameter int MAX_EDGES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // edge_u, edge_v, edge_weight
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // tree_u,tree_v,tree_weight,edge_valid,spanning,edges_dropped
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data       // vertex_count
);
  localparam int MAX_VERTICES = mstb_pkg::MAX_VERTICES;
  localparam int LB = (MAX_VERTICES > 32) ? 6 : 5;
  localparam int AB = $clog2(MAX_EDGES);
  localparam int CB = AB + 1;
  localparam int NB = LB + 1;
  localparam int TB = $clog2(MAX_VERTICES);

  localparam logic [3:0] S_LOAD = 4'd0, S_CLR = 4'd1, S_SCAN = 4'd2, S_SW = 4'd3,
    S_MSEL = 4'd4, S_MRD = 4'd5, S_MCHK = 4'd6, S_RELAB = 4'd7, S_RDONE = 4'd8,
    S_OUTRD = 4'd9, S_OUTW = 4'd10, S_OUT = 4'd11, S_CLEAR = 4'd12;

  logic [3:0] state;
  logic [5:0] vcount;
  logic [CB-1:0] ecount;
  logic over;
  logic [LB-1:0] lab [MAX_VERTICES];
  logic cvalid [MAX_VERTICES];
  logic [AB-1:0] cidx [MAX_VERTICES];
  logic [mstb_pkg::WBITS-1:0] cw [MAX_VERTICES];
  logic [AB-1:0] tidx [MAX_VERTICES];
  logic [NB-1:0] tcount, added, nv, ocnt;
  logic [CB-1:0] scan;
  logic [NB-1:0] comp, x;
  logic [LB-1:0] lo, hi;
  logic rvalid;
  logic [AB-1:0] ridx;

  logic mwe;
  logic [AB-1:0] raddr;
  mstb_pkg::edge_t rd, wd;
  mstb_pkg::result_t res;

  assign cfg_ready = (state == S_LOAD);
  assign s_axis_tready = (state == S_LOAD);
  assign mwe = s_axis_tvalid && s_axis_tready && (ecount < CB'(MAX_EDGES));
  assign wd.u = s_axis_tdata[4:0];
  assign wd.v = s_axis_tdata[9:5];
  assign wd.w = s_axis_tdata[25:10];

  always_comb begin
    if (vcount < 6'd2) nv = NB'(2);
    else if (NB'(vcount) > NB'(MAX_VERTICES)) nv = NB'(MAX_VERTICES);
    else nv = NB'(vcount);
  end

  always_comb begin
    raddr = scan[AB-1:0];
    if (state == S_MSEL || state == S_MRD) raddr = cidx[comp[TB-1:0]];
    if (state == S_OUTRD || state == S_OUTW || state == S_OUT)
      raddr = tidx[ocnt[TB-1:0]];
  end

  mstb_edge_mem #(.DEPTH(MAX_EDGES), .ABITS(AB)) u_mem (
    .clk(clk), .we(mwe), .waddr(ecount[AB-1:0]), .wdata(wd), .raddr(raddr), .rdata(rd));

  logic ok_rng;
  logic [LB-1:0] lu, lv;
  assign ok_rng = (NB'(rd.u) < nv) && (NB'(rd.v) < nv);
  assign lu = lab[rd.u[TB-1:0]];
  assign lv = lab[rd.v[TB-1:0]];

  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata = {3'b0, res.dropped, res.spanning, res.valid, res.w, res.v, res.u};
  assign m_axis_tlast = res.last;
  assign res.u = (tcount == '0) ? '0 : rd.u;
  assign res.v = (tcount == '0) ? '0 : rd.v;
  assign res.w = (tcount == '0) ? '0 : rd.w;
  assign res.valid = (tcount != '0);
  assign res.spanning = (tcount == nv - NB'(1));
  assign res.dropped = over;
  assign res.last = (tcount == '0) || (ocnt == tcount - NB'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      vcount <= 6'd32;
      ecount <= '0;
      over <= 1'b0;
      tcount <= '0;
      for (int i = 0; i < MAX_VERTICES; i++) begin
        lab[i] <= LB'(i);
        cvalid[i] <= 1'b0;
      end
    end else begin
      if (cfg_valid && cfg_ready) vcount <= cfg_data[5:0];
      case (state)
        S_LOAD: begin
          if (s_axis_tvalid) begin
            if (mwe) ecount <= ecount + CB'(1);
            else over <= 1'b1;
            if (s_axis_tlast) state <= S_CLR;
          end
        end
        S_CLR: begin
          if (tcount >= nv - NB'(1)) begin
            ocnt <= '0; state <= S_OUTRD;
          end else begin
            for (int i = 0; i < MAX_VERTICES; i++) cvalid[i] <= 1'b0;
            scan <= '0; added <= '0; rvalid <= 1'b0; state <= S_SCAN;
          end
        end
        S_SCAN: begin
          // raddr = scan; rd holds edge ridx when rvalid
          if (rvalid && ok_rng && lu != lv &&
              (!cvalid[lu[TB-1:0]] || $signed(rd.w) < $signed(cw[lu[TB-1:0]]))) begin
            cvalid[lu[TB-1:0]] <= 1'b1;
            cidx[lu[TB-1:0]] <= ridx;
            cw[lu[TB-1:0]] <= rd.w;
          end
          ridx <= scan[AB-1:0];
          rvalid <= (scan < ecount);
          if (scan < ecount) scan <= scan + CB'(1);
          else if (!rvalid) begin comp <= '0; state <= S_MSEL; end
        end
        S_MSEL: begin
          if (comp >= nv) state <= S_RDONE;
          else if (cvalid[comp[TB-1:0]]) state <= S_MRD;
          else comp <= comp + NB'(1);
        end
        S_MRD: state <= S_MCHK;
        S_MCHK: begin
          if (lu == lv) begin
            comp <= comp + NB'(1); state <= S_MSEL;
          end else begin
            lo <= (lu < lv) ? lu : lv;
            hi <= (lu < lv) ? lv : lu;
            tidx[tcount[TB-1:0]] <= cidx[comp[TB-1:0]];
            tcount <= tcount + NB'(1);
            added <= added + NB'(1);
            x <= '0; state <= S_RELAB;
          end
        end
        S_RELAB: begin
          if (lab[x[TB-1:0]] == hi) lab[x[TB-1:0]] <= lo;
          if (x == NB'(MAX_VERTICES - 1)) begin
            comp <= comp + NB'(1); state <= S_MSEL;
          end else x <= x + NB'(1);
        end
        S_RDONE: begin
          if (added == '0) begin ocnt <= '0; state <= S_OUTRD; end
          else state <= S_CLR;
        end
        S_OUTRD: state <= S_OUTW;
        S_OUTW: state <= S_OUT;
        S_OUT: begin
          if (m_axis_tready) begin
            if (res.last) state <= S_CLEAR;
            else begin ocnt <= ocnt + NB'(1); state <= S_OUTRD; end
          end
        end
        S_CLEAR: begin
          ecount <= '0; over <= 1'b0; tcount <= '0;
          for (int i = 0; i < MAX_VERTICES; i++) lab[i] <= LB'(i);
          state <= S_LOAD;
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  `MSTB_ASSERT(a_no_in_busy, clk, rst, (state != S_LOAD) |-> !s_axis_tready, "ready while busy")
  `MSTB_ASSERT(a_tcount, clk, rst, (tcount <= NB'(MAX_VERTICES - 1)), "tree count overflow")
  `MSTB_ASSERT(a_out_hold, clk, rst, (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid, "out dropped")
endmodule

// ===== test/tb_minimum_spanning_tree_boruvka_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for minimum_spanning_tree_boruvka_top: streams edge graphs,
// predicts the Boruvka tree per graph and checks every result transaction.
// Depends on mstb_pkg and the RTL top level only.

class mst_scoreboard;
  logic [4:0] st_u[256];
  logic [4:0] st_v[256];
  logic signed [15:0] st_w[256];
  int unsigned n_stored;
  bit overflow;
  int unsigned vcount;
  mstb_pkg::result_t tree_q[$];
  int unsigned errors;
  int unsigned checked;

  function new();
    vcount = 32;
    n_stored = 0;
    overflow = 0;
    errors = 0;
    checked = 0;
  endfunction

  function void note_edge(logic [4:0] u, logic [4:0] v, logic signed [15:0] w, bit last);
    int unsigned nv, tn, added, c, i, x;
    logic [4:0] lab[32];
    bit cv[32];
    int unsigned pick[32];
    int unsigned tidx[32];
    logic [4:0] lu, lv, lo, hi;
    mstb_pkg::result_t r;
    if (n_stored < 256) begin
      st_u[n_stored] = u;
      st_v[n_stored] = v;
      st_w[n_stored] = w;
      n_stored++;
    end else begin
      overflow = 1;
    end
    if (!last) return;
    nv = (vcount < 2) ? 2 : (vcount > 32) ? 32 : vcount;
    for (c = 0; c < 32; c++) lab[c] = c[4:0];
    tn = 0;
    while (tn < nv - 1) begin
      added = 0;
      for (c = 0; c < 32; c++) cv[c] = 0;
      for (i = 0; i < n_stored; i++) begin
        if (st_u[i] >= nv || st_v[i] >= nv) continue;
        lu = lab[st_u[i]];
        lv = lab[st_v[i]];
        if (lu == lv) continue;
        if (!cv[lu] || st_w[i] < st_w[pick[lu]]) begin
          cv[lu] = 1;
          pick[lu] = i;
        end
      end
      for (c = 0; c < nv; c++) begin
        if (!cv[c]) continue;
        lu = lab[st_u[pick[c]]];
        lv = lab[st_v[pick[c]]];
        if (lu == lv) continue;
        lo = (lu < lv) ? lu : lv;
        hi = (lu < lv) ? lv : lu;
        for (x = 0; x < nv; x++)
          if (lab[x] == hi) lab[x] = lo;
        tidx[tn] = pick[c];
        tn++;
        added++;
      end
      if (added == 0) break;
    end
    if (tn == 0) begin
      r = '0;
      r.dropped = overflow;
      r.last = 1;
      tree_q.insert(tree_q.size(), r);
    end
    for (i = 0; i < tn; i++) begin
      r.u = st_u[tidx[i]];
      r.v = st_v[tidx[i]];
      r.w = st_w[tidx[i]];
      r.valid = 1;
      r.spanning = (tn == nv - 1);
      r.dropped = overflow;
      r.last = (i == tn - 1);
      tree_q.insert(tree_q.size(), r);
    end
    n_stored = 0;
    overflow = 0;
  endfunction

  function void check_result(logic [31:0] data, logic last);
    mstb_pkg::result_t exp_r;
    checked++;
    if (tree_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected result transaction data=%h last=%b", $time, data, last);
      return;
    end
    exp_r = tree_q.pop_front();
    if (data[4:0] !== exp_r.u || data[9:5] !== exp_r.v || data[25:10] !== exp_r.w ||
        data[26] !== exp_r.valid || data[27] !== exp_r.spanning ||
        data[28] !== exp_r.dropped || data[31:29] !== 3'b000 || last !== exp_r.last) begin
      errors++;
      $display("%0t: mismatch expected u=%0d v=%0d w=%0d ev=%b sp=%b dr=%b last=%b",
               $time, exp_r.u, exp_r.v, $signed(exp_r.w), exp_r.valid, exp_r.spanning,
               exp_r.dropped, exp_r.last);
      $display("%0t:          actual   u=%0d v=%0d w=%0d ev=%b sp=%b dr=%b last=%b",
               $time, data[4:0], data[9:5], $signed(data[25:10]), data[26], data[27],
               data[28], last);
    end
  endfunction
endclass

module tb_minimum_spanning_tree_boruvka_top;
  localparam int CYCLE_LIMIT = 2000000;

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // edge_u[4:0], edge_v[9:5], edge_weight[25:10]
  logic s_axis_tlast = 0;           // last_edge
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [31:0] m_axis_tdata;        // tree_u, tree_v, tree_weight, edge_valid, spanning,
                                    // edges_dropped
  logic m_axis_tlast;               // last_result
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [7:0] cfg_data = '0;        // vertex_count

  mst_scoreboard sb;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit hold_off = 0;
  int unsigned cycles = 0;
  int unsigned items = 0;
  int unsigned graphs = 0;

  minimum_spanning_tree_boruvka_top dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_minimum_spanning_tree_boruvka_top: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tlast);
    m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_edge(input logic [4:0] u, input logic [4:0] v,
                           input logic [15:0] w, input bit last);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {6'b0, w, v, u};
    s_axis_tlast <= last;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_edge(u, v, w, last);
    items++;
    if (last) graphs++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    do @(posedge clk); while (sb.tree_q.size() != 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_vcount(input logic [7:0] val);
    cfg_valid <= 1;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    sb.vcount = val[5:0];
  endtask

  // Mostly connected graphs: a random spanning skeleton plus extra and out-of-range edges.
  task automatic random_graph(input int unsigned extra, input bit connected,
                              input bit narrow_w);
    logic [4:0] eu[$];
    logic [4:0] ev[$];
    logic [4:0] a, b;
    int unsigned nv, i, j;
    logic [15:0] w;
    nv = (sb.vcount < 2) ? 2 : (sb.vcount > 32) ? 32 : sb.vcount;
    if (connected)
      for (i = 1; i < nv; i++) begin
        a = 5'($urandom_range(i - 1));
        b = 5'(i);
        if ($urandom_range(1)) begin
          eu.insert(eu.size(), a); ev.insert(ev.size(), b);
        end else begin
          eu.insert(eu.size(), b); ev.insert(ev.size(), a);
        end
      end
    for (i = 0; i < extra; i++) begin
      if ($urandom_range(9) == 0) begin
        eu.insert(eu.size(), 5'($urandom_range(31)));
        ev.insert(ev.size(), 5'($urandom_range(31)));
      end else begin
        eu.insert(eu.size(), 5'($urandom_range(nv - 1)));
        ev.insert(ev.size(), 5'($urandom_range(nv - 1)));
      end
    end
    if (eu.size() == 0) begin
      eu.insert(0, 5'd0); ev.insert(0, 5'd0);
    end
    for (i = eu.size() - 1; i > 0; i--) begin
      j = $urandom_range(i);
      a = eu[i]; eu[i] = eu[j]; eu[j] = a;
      b = ev[i]; ev[i] = ev[j]; ev[j] = b;
    end
    for (i = 0; i < eu.size(); i++) begin
      w = narrow_w ? 16'($urandom_range(3)) - 16'd1 : 16'($urandom);
      send_edge(eu[i], ev[i], w, i == eu.size() - 1);
    end
  endtask

  initial begin
    int unsigned g, sel, i;
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: smallest graph, extreme weights, self loop only, out of range, ties
    write_vcount(8'd2);
    send_edge(5'd0, 5'd1, 16'h8000, 1);
    send_edge(5'd1, 5'd1, 16'h7fff, 1);
    send_edge(5'd31, 5'd0, 16'h0000, 0);
    send_edge(5'd1, 5'd0, 16'h7fff, 0);
    send_edge(5'd0, 5'd1, 16'h7fff, 1);
    drain();
    write_vcount(8'd32);
    send_edge(5'd0, 5'd31, 16'h0005, 0);
    send_edge(5'd31, 5'd30, 16'hffff, 0);
    send_edge(5'd7, 5'd8, 16'h0005, 0);
    send_edge(5'd8, 5'd7, 16'h0005, 0);
    send_edge(5'd16, 5'd15, 16'h5555, 0);
    send_edge(5'd10, 5'd21, 16'haaaa, 1);
    drain();
    write_vcount(8'd4);
    send_edge(5'd0, 5'd1, 16'h0001, 0);
    send_edge(5'd1, 5'd2, 16'h0001, 0);
    send_edge(5'd2, 5'd3, 16'h0001, 0);
    send_edge(5'd3, 5'd0, 16'h0001, 0);
    send_edge(5'd0, 5'd2, 16'h8000, 0);
    send_edge(5'd4, 5'd1, 16'h8000, 1);
    drain();
    write_vcount(8'd0);
    send_edge(5'd1, 5'd0, 16'h1234, 1);
    drain();
    write_vcount(8'd63);
    random_graph(4, 1, 0);

    // receiver holds off while a full graph waits for output and the next one stalls
    drain();
    write_vcount(8'd32);
    fork
      begin
        hold_off = 1;
        repeat (3000) @(posedge clk);
        hold_off = 0;
      end
      begin
        random_graph(10, 1, 1);
        random_graph(3, 1, 0);
      end
    join

    // store overflow
    drain();
    write_vcount(8'd12);
    for (i = 0; i < 262; i++)
      send_edge(5'($urandom_range(11)), 5'($urandom_range(11)), 16'($urandom), i == 261);

    g = 0;
    while (items < 470) begin
      case (g % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 54; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 54; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      if (g % 3 == 0) begin
        drain();
        sel = $urandom_range(9);
        if (sel == 0) write_vcount(8'd2);
        else if (sel == 1) write_vcount(8'd32);
        else if (sel == 2)
          write_vcount(8'($urandom_range(1) ? 1 : 33 + $urandom_range(30)));
        else write_vcount(8'($urandom_range(3, 12)));
      end
      random_graph($urandom_range(8), $urandom_range(5) != 0, $urandom_range(2) == 0);
      g++;
    end

    drain();
    $display("ran %0d graphs from %0d edge transactions, %0d tree results checked",
             graphs, items, sb.checked);
    $display("covered overflow, self loops, out-of-range vertices, ties and disconnects");
    if (sb.errors == 0) begin
      $display("tb_minimum_spanning_tree_boruvka_top: PASS");
    end else begin
      $display("tb_minimum_spanning_tree_boruvka_top: FAIL");
    end
    $finish;
  end
endmodule
